// File: rtl/amicable_sum_divisor_sieve_core_defines.svh
// Assertion macros used by the sieve engine.
`ifndef AMICABLE_SUM_DIVISOR_SIEVE_CORE_DEFINES_SVH
`define AMICABLE_SUM_DIVISOR_SIEVE_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define ASDS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define ASDS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/asds_pkg.sv
`default_nettype none

package asds_pkg;

   // fixed field widths
   localparam int LIMIT_W = 17;
   localparam int ENTRY_W = 20;
   localparam int TOTAL_W = 40;

   // saturation value of a table entry
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;

   // top level to engine
   typedef struct packed {
      logic start;      // launch a new item
      logic res_ready;  // result register can take a beat
   } ctrl_type;

   // engine to top level
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [TOTAL_W-1:0] total;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/amicable_sum_divisor_sieve_core.sv
`default_nettype none

// Channel   Direction  Beat                          Handshake
// req_      in         limit, 17 bit unsigned        req_valid / req_stall
// rsp_      out        amicable_total, 40 bit        rsp_valid / rsp_stall
//
// One item at a time. An item of limit n (saturated to MAX_LIMIT) clears the
// table, runs the sieve with one update per cycle, drains the last write-back
// and scans for pairs. Reset clears control only: every table entry an item
// reads is written earlier by the same item. The finished total sits in the
// output register, so a new item is taken while rsp_stall holds the old one.
module amicable_sum_divisor_sieve_core #(
   parameter int MAX_LIMIT = 65536
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [asds_pkg::LIMIT_W-1:0]       req_limit,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [asds_pkg::TOTAL_W-1:0]       rsp_amicable_total
);

   localparam int AW = $clog2(MAX_LIMIT);
   localparam int NW = AW + 1;
   localparam int CW = (NW > asds_pkg::LIMIT_W) ? NW : asds_pkg::LIMIT_W;

   asds_pkg::ctrl_type             ctrl;
   asds_pkg::stat_type             stat;
   logic [CW-1:0]                  lim_ext;
   logic [NW-1:0]                  n_sat;
   logic                           rsp_valid_ff;
   logic [asds_pkg::TOTAL_W-1:0]   rsp_amicable_total_ff;

   // limit saturates to the table depth
   assign lim_ext = CW'(req_limit);
   assign n_sat   = (lim_ext > CW'(MAX_LIMIT)) ? NW'(MAX_LIMIT) : NW'(lim_ext);

   assign req_stall      = stat.busy;
   assign ctrl.start     = req_valid && !stat.busy;
   assign ctrl.res_ready = !rsp_valid_ff || !rsp_stall;

   asds_engine #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .start_n (n_sat),
      .stat    (stat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_amicable_total_ff <= stat.total;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_amicable_total = rsp_amicable_total_ff;

endmodule

`default_nettype wire

// File: rtl/asds_engine.sv
`default_nettype none

`include "amicable_sum_divisor_sieve_core_defines.svh"

module asds_engine #(
   parameter int MAX_LIMIT = 65536
) (
   input  wire                       clock,
   input  wire                       reset,
   input  asds_pkg::ctrl_type        ctrl,
   input  wire  [$clog2(MAX_LIMIT):0] start_n,
   output asds_pkg::stat_type        stat
);

   localparam int AW    = $clog2(MAX_LIMIT);
   localparam int NW    = AW + 1;
   localparam int CMPW  = (NW > asds_pkg::ENTRY_W) ? NW : asds_pkg::ENTRY_W;
   localparam int SUMW  = CMPW + 1;

   typedef enum logic [2:0] {
      IDLE,
      CLEAR,
      SIEVE,
      DRAIN,
      SCAN_RD,
      SCAN_CHK,
      SCAN_PAIR,
      FINISH
   } state_type;

   state_type                       state_ff;
   logic [NW-1:0]                   n_ff;
   logic [NW-1:0]                   cc_ff;
   logic [NW-1:0]                   ii_ff;
   logic [NW-1:0]                   jj_ff;
   logic [asds_pkg::ENTRY_W-1:0]    sv_ff;
   logic [asds_pkg::TOTAL_W-1:0]    total_ff;

   // write-back stage of the sieve read-modify-write
   logic                            pend_vld_ff;
   logic [AW-1:0]                   pend_addr_ff;
   logic [NW-1:0]                   pend_add_ff;

   // divisor sum table
   logic [asds_pkg::ENTRY_W-1:0]    mem [MAX_LIMIT];
   logic [asds_pkg::ENTRY_W-1:0]    rd_data_ff;

   logic [AW-1:0]                   rd_addr;
   logic                            rd_en;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [asds_pkg::ENTRY_W-1:0]    wr_data;

   logic [SUMW-1:0]                 sum_w;
   logic [asds_pkg::ENTRY_W-1:0]    sum_sat;
   logic [NW:0]                     jj_next;
   logic [NW:0]                     ii_next;
   logic                            sieve_more_j;
   logic                            idx_more;
   logic [CMPW-1:0]                 s_ext;
   logic                            cand;
   logic                            pair_hit;
   logic                            done;

   // saturating accumulate for the write-back stage
   assign sum_w   = SUMW'(rd_data_ff) + SUMW'(pend_add_ff);
   assign sum_sat = (sum_w > SUMW'(asds_pkg::ENTRY_MAX)) ? asds_pkg::ENTRY_MAX
                                                         : sum_w[asds_pkg::ENTRY_W-1:0];

   // loop bounds
   assign jj_next      = {1'b0, jj_ff} + {1'b0, ii_ff};
   assign ii_next      = {1'b0, ii_ff} + {{NW{1'b0}}, 1'b1};
   assign sieve_more_j = jj_next < {1'b0, n_ff};
   assign idx_more     = ii_next < {1'b0, n_ff};

   // scan tests: i < s(i) < n, s(i) not saturated, then s(s(i)) = i
   assign s_ext    = CMPW'(rd_data_ff);
   assign cand     = (rd_data_ff != asds_pkg::ENTRY_MAX) &&
                     (s_ext < CMPW'(n_ff)) && (CMPW'(ii_ff) < s_ext);
   assign pair_hit = s_ext == CMPW'(ii_ff);

   assign done = (state_ff == FINISH) && ctrl.res_ready;

   // memory port control
   always_comb begin
      rd_addr = '0;
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         CLEAR: begin
            if (cc_ff < n_ff) begin
               wr_en   = 1'b1;
               wr_addr = cc_ff[AW-1:0];
            end
         end
         SIEVE: begin
            rd_en   = 1'b1;
            rd_addr = jj_ff[AW-1:0];
         end
         SCAN_RD: begin
            rd_en   = 1'b1;
            rd_addr = ii_ff[AW-1:0];
         end
         SCAN_CHK: begin
            rd_en   = cand;
            rd_addr = rd_data_ff[AW-1:0];
         end
         default: begin
         end
      endcase
      if (pend_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = sum_sat;
      end
   end

   // table storage, one read and one write per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         pend_vld_ff <= 1'b0;
      end else begin
         pend_vld_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (ctrl.start) begin
                  n_ff     <= start_n;
                  cc_ff    <= '0;
                  total_ff <= '0;
                  state_ff <= CLEAR;
               end
            end
            CLEAR: begin
               if (cc_ff < n_ff) begin
                  cc_ff <= cc_ff + NW'(1);
               end else if (n_ff > NW'(2)) begin
                  ii_ff    <= NW'(2);
                  jj_ff    <= NW'(2);
                  state_ff <= SIEVE;
               end else begin
                  state_ff <= FINISH;
               end
            end
            SIEVE: begin
               // entry i gets 1, its multiples get i
               pend_vld_ff  <= 1'b1;
               pend_addr_ff <= jj_ff[AW-1:0];
               pend_add_ff  <= (jj_ff == ii_ff) ? NW'(1) : ii_ff;
               if (sieve_more_j) begin
                  jj_ff <= jj_next[NW-1:0];
               end else if (idx_more) begin
                  ii_ff <= ii_next[NW-1:0];
                  jj_ff <= ii_next[NW-1:0];
               end else begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               // last write-back lands here
               ii_ff    <= NW'(2);
               state_ff <= SCAN_RD;
            end
            SCAN_RD: begin
               state_ff <= SCAN_CHK;
            end
            SCAN_CHK: begin
               sv_ff <= rd_data_ff;
               if (cand) begin
                  state_ff <= SCAN_PAIR;
               end else if (idx_more) begin
                  ii_ff    <= ii_next[NW-1:0];
                  state_ff <= SCAN_RD;
               end else begin
                  state_ff <= FINISH;
               end
            end
            SCAN_PAIR: begin
               if (pair_hit) begin
                  total_ff <= total_ff + asds_pkg::TOTAL_W'(ii_ff)
                                       + asds_pkg::TOTAL_W'(sv_ff);
               end
               if (idx_more) begin
                  ii_ff    <= ii_next[NW-1:0];
                  state_ff <= SCAN_RD;
               end else begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (ctrl.res_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign stat.busy  = state_ff != IDLE;
   assign stat.done  = done;
   assign stat.total = total_ff;

   // checks
   `ASDS_ASSERT_IMP(a_no_rmw_overlap, clock, reset, pend_vld_ff && rd_en, rd_addr != pend_addr_ff, "read hits entry under write-back")
   `ASDS_ASSERT_IMP(a_start_when_idle, clock, reset, ctrl.start, state_ff == IDLE, "start while busy")
   `ASDS_ASSERT_IMP(a_pair_below_n, clock, reset, state_ff == SCAN_PAIR, CMPW'(sv_ff) < CMPW'(n_ff), "partner index out of range")
   `ASDS_ASSERT_NXT(a_done_to_idle, clock, reset, done, state_ff == IDLE && !pend_vld_ff, "engine not idle after result")

endmodule

`default_nettype wire

// File: test/amicable_sum_divisor_sieve_core_checker.sv
module amicable_sum_divisor_sieve_core_checker #(
   parameter int MAX_LIMIT = 65536
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_stall,
   input  wire  [asds_pkg::LIMIT_W-1:0] req_limit,
   input  wire                          rsp_valid,
   input  wire                          rsp_stall,
   input  wire  [asds_pkg::TOTAL_W-1:0] rsp_amicable_total,
   input  wire                          run_done,
   output int                           fail_count,
   output int                           pending_count,
   output int                           checked_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [asds_pkg::LIMIT_W-1:0] limit;
      logic [asds_pkg::TOTAL_W-1:0] total;
   } total_entry_type;

   // private copy of the divisor-sum table
   logic [asds_pkg::ENTRY_W-1:0] aliquot_sum [MAX_LIMIT];

   total_entry_type              pending_totals [$];
   logic                         held;
   logic [asds_pkg::TOTAL_W-1:0] held_total;
   logic                         end_checked;

   // table entry add, clamped at the entry maximum
   function automatic logic [asds_pkg::ENTRY_W-1:0] entry_plus(
         input logic [asds_pkg::ENTRY_W-1:0] e,
         input int unsigned v);
      logic [31:0] sum;
      sum = 32'(e) + v;
      return (sum > 32'(asds_pkg::ENTRY_MAX)) ? asds_pkg::ENTRY_MAX
                                               : sum[asds_pkg::ENTRY_W-1:0];
   endfunction

   // sieve the aliquot sums below the limit, then total the amicable pairs
   function automatic logic [asds_pkg::TOTAL_W-1:0] amicable_total_for(
         input logic [asds_pkg::LIMIT_W-1:0] lim);
      int unsigned                  n;
      int unsigned                  i;
      int unsigned                  j;
      int unsigned                  s;
      logic [asds_pkg::TOTAL_W-1:0] acc;
      n = (lim > MAX_LIMIT) ? MAX_LIMIT : lim;
      for (i = 0; i < n; i++)
         aliquot_sum[i] = '0;
      for (i = 2; i < n; i++) begin
         aliquot_sum[i] = entry_plus(aliquot_sum[i], 1);
         for (j = i + i; j < n; j += i)
            aliquot_sum[j] = entry_plus(aliquot_sum[j], i);
      end
      acc = '0;
      // smaller member only; partner must lie below the limit too
      for (i = 2; i < n; i++) begin
         s = aliquot_sum[i];
         if (s != asds_pkg::ENTRY_MAX && s < n && i < s && aliquot_sum[s] == i)
            acc = acc + asds_pkg::TOTAL_W'(i) + asds_pkg::TOTAL_W'(s);
      end
      return acc;
   endfunction

   always @(posedge clock) begin
      total_entry_type exp_entry;
      total_entry_type new_entry;
      if (reset) begin
         fail_count    = 0;
         pending_count = 0;
         checked_count = 0;
         held          = 1'b0;
         held_total    = '0;
         end_checked   = 1'b0;
      end else begin
         // a stalled result must hold
         if (held && (!rsp_valid || rsp_amicable_total != held_total)) begin
            $display("%0t: stalled result changed: expected %0d, actual valid %0b total %0d",
                     $realtime, held_total, rsp_valid, rsp_amicable_total);
            fail_count++;
         end
         held       = rsp_valid && rsp_stall;
         held_total = rsp_amicable_total;

         // result beat against oldest expectation
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (pending_totals.size() == 0) begin
               $display("%0t: result with nothing expected: expected none, actual %0d",
                        $realtime, rsp_amicable_total);
               fail_count++;
            end else begin
               exp_entry = pending_totals.pop_front();
               if (rsp_amicable_total !== exp_entry.total) begin
                  $display("%0t: limit %0d amicable_total: expected %0d, actual %0d",
                           $realtime, exp_entry.limit, exp_entry.total, rsp_amicable_total);
                  fail_count++;
               end
            end
         end

         // request beat: predict its total
         if (req_valid && !req_stall) begin
            new_entry.limit = req_limit;
            new_entry.total = amicable_total_for(req_limit);
            pending_totals.push_back(new_entry);
         end

         if (run_done && !end_checked) begin
            end_checked = 1'b1;
            if (pending_totals.size() != 0) begin
               $display("%0t: totals never returned: expected 0 outstanding, actual %0d",
                        $realtime, pending_totals.size());
               fail_count++;
            end
         end
         pending_count = pending_totals.size();
      end
   end

endmodule

// File: test/amicable_sum_divisor_sieve_core_tb.sv
module amicable_sum_divisor_sieve_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LIMIT    = 65536;
   localparam int RANDOM_ITEMS = 79;
   localparam int IDLE_LIMIT   = 4_000_000;
   localparam int DRAIN_CYCLES = 16;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic [asds_pkg::LIMIT_W-1:0] req_limit = '0;
   logic                         rsp_stall = 1'b0;
   logic                         run_done  = 1'b0;
   wire                          req_stall;
   wire                          rsp_valid;
   wire  [asds_pkg::TOTAL_W-1:0] rsp_amicable_total;

   int fail_count;
   int pending_count;
   int checked_count;

   logic        quiet      = 1'b0;
   int          stall_left = 0;
   int          rsp_beats  = 0;
   int          beats_seen = 0;
   int          idle_count = 0;
   int          sent_count = 0;
   int unsigned top_limit  = 0;

   // below two, perfect numbers, partners either side of the limit,
   // all pairs within reach, table depth and saturation above it
   int unsigned directed_limits [21] = '{
      0, 1, 2, 3, 4, 6, 28, 219, 220, 221, 284, 285, 496, 497,
      1210, 1211, 8128, 8129, 18417, 65536, 131071
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   amicable_sum_divisor_sieve_core #(
      .MAX_LIMIT(MAX_LIMIT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_limit          (req_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_amicable_total (rsp_amicable_total)
   );

   amicable_sum_divisor_sieve_core_checker #(
      .MAX_LIMIT(MAX_LIMIT)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_limit          (req_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_amicable_total (rsp_amicable_total),
      .run_done           (run_done),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   // one request beat, after a random gap; valid stays up when there is no gap
   task automatic send_limit(input int unsigned lim);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_limit <= lim[asds_pkg::LIMIT_W-1:0];
      do @(posedge clock); while (req_stall);
      sent_count++;
      if (lim > top_limit)
         top_limit = lim;
      @(negedge clock);
   endtask

   // result side: count accepted beats, then randomly stall the next beat unless quiet
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         rsp_beats++;
   end

   always @(negedge clock) begin
      if (rsp_beats != beats_seen) begin
         beats_seen = rsp_beats;
         stall_left = quiet ? 0 : $urandom_range(0, 3);
      end
      if (rsp_valid && stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count = 0;
      end else begin
         idle_count++;
         if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, idle_count);
            $display("amicable_sum_divisor_sieve_core_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int          r;
      int unsigned lim;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_limits[k])
         send_limit(directed_limits[k]);

      // mostly small limits, some mid-range, a few up to 19000
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if ($urandom_range(0, 15) == 0)
            quiet = !quiet;
         r = $urandom_range(0, 99);
         if (r < 5)
            lim = $urandom_range(0, 1);
         else if (r < 80)
            lim = $urandom_range(2, 700);
         else if (r < 96)
            lim = $urandom_range(700, 6500);
         else
            lim = $urandom_range(6500, 19000);
         send_limit(lim);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      run_done <= 1'b1;
      @(negedge clock);
      @(negedge clock);

      $display("Sent %0d limits (largest %0d, table depth %0d), checked %0d totals.",
               sent_count, top_limit, MAX_LIMIT, checked_count);
      $display("Covered limits below two, perfect numbers, split pairs and saturation.");
      if (fail_count == 0)
         $display("amicable_sum_divisor_sieve_core_tb: PASS");
      else
         $display("amicable_sum_divisor_sieve_core_tb: FAIL");
      $finish;
   end

endmodule
